// ===== design/battery_time_estimator_defines.svh =====
// Assertion macros shared by the battery time estimator RTL.
`ifndef BATTERY_TIME_ESTIMATOR_DEFINES_SVH
`define BATTERY_TIME_ESTIMATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define BTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/bte_pkg.sv =====
// Types and constants of the battery time estimator.
`timescale 1ns / 1ps
`default_nettype none
package bte_pkg;
    localparam int CAP_W     = 14;
    localparam int TIME_W    = 32;
    localparam int PCT_W     = 7;
    localparam int FRAC_BITS = 16;
    localparam int AVG_W     = 32 + FRAC_BITS;
    localparam int DIV_W     = AVG_W + 6;
    localparam int NB_W      = 6;
    localparam int EST_W     = 31;

    localparam logic [CAP_W-1:0] FULL_SCALE_RESET = 14'd10000;
    localparam logic [PCT_W-1:0] FULL_PCT_RESET   = 7'd98;
    localparam logic [20:0]      PERCENT_SCALE    = 21'd100;

    // register indexes on the configuration port
    localparam logic REG_FULL_SCALE = 1'b0;
    localparam logic REG_FULL_PCT   = 1'b1;

    // -1.0 in Q32.F
    localparam logic [AVG_W-1:0] AVG_RESET = {{(AVG_W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic [DIV_W-1:0] AVG_MAX_MAG = DIV_W'((64'd1 << (AVG_W-1)) - 64'd1);
    localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

    localparam logic [NB_W-1:0] NB_INTERVAL = NB_W'(TIME_W + FRAC_BITS);
    localparam logic [NB_W-1:0] NB_AVERAGE  = NB_W'(DIV_W);

    typedef struct packed {
        logic [CAP_W-1:0]  cap;
        logic [TIME_W-1:0] stamp;
        logic              chg;
        logic              clear;
        logic              store;
    } bte_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bte_q_stat_t;
endpackage
`default_nettype wire

// ===== design/battery_time_estimator.sv =====
// Each history interval with a capacity change, and then the average, goes through the
// shared 1-bit/cycle divider; an interval with no capacity change skips the divider.
// One sample is worked on at a time; a two-entry queue takes the next ones meanwhile.
// Filtered samples (zero or repeated capacity) leave no work and are taken every cycle
// while the queue has room. Reset (rst_n, async, active low): configuration to 10000 and
// 98, history empty, both rate averages -1.0; history memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_time_estimator_defines.svh"
module battery_time_estimator #(
    parameter int MAX_INTERVALS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [bte_pkg::CAP_W-1:0]   capacity_reading,
    input  wire logic [bte_pkg::TIME_W-1:0]  sample_seconds,
    input  wire logic                        is_charging,
    input  wire logic                        charge_full,
    input  wire logic                        woke_up,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [bte_pkg::EST_W-1:0]        estimate_seconds,
    output logic                             estimate_kind
);
    logic [bte_pkg::CAP_W-1:0] fs_reg;
    logic [bte_pkg::PCT_W-1:0] pct_reg;
    logic                      cfg_wr;
    logic                      q_push, q_pop;
    bte_pkg::bte_cmd_t         q_cmd, q_head;
    bte_pkg::bte_q_stat_t      q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration read mux
    always_comb
    begin
        case (paddr[2])
            bte_pkg::REG_FULL_SCALE: prdata = {18'b0, fs_reg};
            bte_pkg::REG_FULL_PCT:   prdata = {25'b0, pct_reg};
            default:                 prdata = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg  <= bte_pkg::FULL_SCALE_RESET;
            pct_reg <= bte_pkg::FULL_PCT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bte_pkg::REG_FULL_SCALE)
            begin
                fs_reg <= pwdata[bte_pkg::CAP_W-1:0];
            end
            else
            begin
                pct_reg <= pwdata[bte_pkg::PCT_W-1:0];
            end
        end
    end

    bte_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .capacity_reading (capacity_reading),
        .sample_seconds   (sample_seconds),
        .is_charging      (is_charging),
        .charge_full      (charge_full),
        .woke_up          (woke_up),
        .full_scale       (fs_reg),
        .full_percent     (pct_reg),
        .q_stat           (q_stat),
        .q_push           (q_push),
        .q_cmd            (q_cmd)
    );

    bte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    bte_back #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_stat           (q_stat),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .full_scale       (fs_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .estimate_seconds (estimate_seconds),
        .estimate_kind    (estimate_kind)
    );

    `BTE_ASSERT_IMPL(a_no_overflow, clk, rst_n, q_push, !q_stat.full)
    `BTE_ASSERT_IMPL(a_drop_zero, clk, rst_n, in_valid && !in_stall && capacity_reading == '0, !q_push)
    `BTE_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push && q_stat.empty, !q_stat.empty)
    `BTE_ASSERT_IMPL(a_est_nonzero, clk, rst_n, out_valid, estimate_seconds != '0)
endmodule
`default_nettype wire

// ===== design/bte_front.sv =====
// Front end: accepts samples, filters them and decides history clearing.
`timescale 1ns / 1ps
`default_nettype none
module bte_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [bte_pkg::CAP_W-1:0]    capacity_reading,
    input  wire logic [bte_pkg::TIME_W-1:0]   sample_seconds,
    input  wire logic                         is_charging,
    input  wire logic                         charge_full,
    input  wire logic                         woke_up,
    input  wire logic [bte_pkg::CAP_W-1:0]    full_scale,
    input  wire logic [bte_pkg::PCT_W-1:0]    full_percent,
    input  wire bte_pkg::bte_q_stat_t         q_stat,
    output logic                              q_push,
    output bte_pkg::bte_cmd_t                 q_cmd
);
    logic [bte_pkg::CAP_W-1:0] last_cap_reg, last_cap_next;
    logic                      chg_reg, chg_next;
    logic                      wake_reg, wake_next;
    logic                      accept, ignore, wake_any, near_full, mode_change;
    logic [20:0]               cap_scaled, threshold;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    // classify the beat
    always_comb
    begin
        wake_any    = wake_reg | woke_up;
        ignore      = (capacity_reading == '0) || (capacity_reading == last_cap_reg);
        cap_scaled  = 21'(capacity_reading) * bte_pkg::PERCENT_SCALE;
        threshold   = 21'(full_percent) * 21'(full_scale);
        near_full   = (cap_scaled >= threshold) && charge_full;
        mode_change = chg_reg != is_charging;

        q_cmd.cap   = capacity_reading;
        q_cmd.stamp = sample_seconds;
        q_cmd.chg   = is_charging;
        if (is_charging)
        begin
            q_cmd.clear = mode_change | near_full;
            q_cmd.store = !near_full;
        end
        else
        begin
            q_cmd.clear = mode_change | wake_any;
            q_cmd.store = 1'b1;
        end
        q_push = accept && !ignore;

        last_cap_next = last_cap_reg;
        chg_next      = chg_reg;
        wake_next     = wake_reg;
        if (accept)
        begin
            wake_next = wake_any;
            if (!ignore)
            begin
                last_cap_next = capacity_reading;
                chg_next      = is_charging;
                if (!is_charging)
                begin
                    wake_next = 1'b0;
                end
            end
        end
    end

    // hold front state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cap_reg <= '0;
            chg_reg      <= 1'b0;
            wake_reg     <= 1'b0;
        end
        else
        begin
            last_cap_reg <= last_cap_next;
            chg_reg      <= chg_next;
            wake_reg     <= wake_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/bte_queue.sv =====
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module bte_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bte_pkg::bte_cmd_t push_cmd,
    input  wire logic              pop,
    output bte_pkg::bte_cmd_t      head,
    output bte_pkg::bte_q_stat_t   stat
);
    bte_pkg::bte_cmd_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = count_reg == 2'd2;
    assign stat.empty = count_reg == 2'd0;

    // advance pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== design/bte_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bte_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bte_pkg::DIV_W-1:0]   dividend,
    input  wire logic [bte_pkg::CAP_W-1:0]   divisor,
    input  wire logic [bte_pkg::NB_W-1:0]    nbits,
    output logic                             done,
    output logic [bte_pkg::DIV_W-1:0]        quotient
);
    logic [bte_pkg::DIV_W-1:0] num_reg, num_next;
    logic [bte_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [bte_pkg::CAP_W-1:0] rem_reg, rem_next;
    logic [bte_pkg::CAP_W-1:0] dsr_reg, dsr_next;
    logic [bte_pkg::NB_W-1:0]  cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [bte_pkg::CAP_W:0]   trial;
    logic                      ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one subtract-and-shift step
    always_comb
    begin
        trial     = {rem_reg, num_reg[bte_pkg::DIV_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = nbits;
        end
        else if (cnt_reg != '0)
        begin
            num_next  = {num_reg[bte_pkg::DIV_W-2:0], 1'b0};
            quo_next  = {quo_reg[bte_pkg::DIV_W-2:0], ge};
            rem_next  = ge ? bte_pkg::CAP_W'(trial - {1'b0, dsr_reg}) : trial[bte_pkg::CAP_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = cnt_reg == bte_pkg::NB_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end
endmodule
`default_nettype wire

// ===== design/bte_back.sv =====
// Back end: sample history, rate averaging and estimate output.
`timescale 1ns / 1ps
`default_nettype none
module bte_back #(
    parameter int MAX_INTERVALS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bte_pkg::bte_q_stat_t        q_stat,
    input  wire bte_pkg::bte_cmd_t           q_head,
    output logic                             q_pop,
    input  wire logic [bte_pkg::CAP_W-1:0]   full_scale,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [bte_pkg::EST_W-1:0]        estimate_seconds,
    output logic                             estimate_kind
);
    localparam int DEPTH = MAX_INTERVALS + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam int AW = bte_pkg::AVG_W;
    localparam int DW = bte_pkg::DIV_W;
    localparam int FB = bte_pkg::FRAC_BITS;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_LOAD = 10'b0000000010,
        S_READ = 10'b0000000100,
        S_WAIT = 10'b0000001000,
        S_DIV  = 10'b0000010000,
        S_NEXT = 10'b0000100000,
        S_AVG  = 10'b0001000000,
        S_MUL  = 10'b0010000000,
        S_SUM  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } bte_state_t;

    bte_state_t state_reg, state_next;

    // history memory
    logic [bte_pkg::TIME_W-1:0] mem_t [DEPTH];
    logic [bte_pkg::CAP_W-1:0]  mem_l [DEPTH];
    logic [bte_pkg::TIME_W-1:0] rd_t_reg;
    logic [bte_pkg::CAP_W-1:0]  rd_l_reg;
    logic                       mem_we, rd_en;
    logic [IDX_W-1:0]           wr_idx;

    bte_pkg::bte_cmd_t          cmd_reg, cmd_next;
    logic [IDX_W-1:0]           newest_reg, newest_next, newest_inc;
    logic [IDX_W-1:0]           ptr_reg, ptr_next, ptr_dec;
    logic [CNT_W-1:0]           count_reg, count_next, cnt_base, cnt_new, n_int;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [bte_pkg::TIME_W-1:0] prev_t_reg, prev_t_next;
    logic [bte_pkg::CAP_W-1:0]  prev_l_reg, prev_l_next;
    logic                       tneg_reg, tneg_next;
    logic                       sneg_reg, sneg_next;
    logic signed [DW-1:0]       sum_reg, sum_next;
    logic [AW-1:0]              rate_reg [2];
    logic [AW-1:0]              rate_next [2];
    logic [AW-1:0]              avg_reg, avg_next;
    logic [45:0]                phi_reg, phi_next;
    logic [29:0]                plo_reg, plo_next;
    logic [bte_pkg::EST_W-1:0]  est_reg, est_next;
    logic                       outv_reg, outv_next;
    logic [bte_pkg::EST_W-1:0]  oest_reg;
    logic                       okind_reg;
    logic                       out_load;

    // divider hookup and datapath temporaries
    logic                       div_start, div_done;
    logic [DW-1:0]              div_dividend, div_quot;
    logic [bte_pkg::CAP_W-1:0]  div_divisor;
    logic [bte_pkg::NB_W-1:0]   div_nbits;
    logic [bte_pkg::TIME_W:0]   tdiff;
    logic [bte_pkg::TIME_W-1:0] tmag;
    logic [bte_pkg::CAP_W-1:0]  cdiff;
    logic [DW-1:0]              mag, qv;
    logic [AW-1:0]              avg_new, a_abs;
    logic [bte_pkg::CAP_W:0]    mult;
    logic [bte_pkg::CAP_W-1:0]  m_abs;
    logic [46:0]                r_sum;

    bte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid        = outv_reg;
    assign estimate_seconds = oest_reg;
    assign estimate_kind    = okind_reg;

    assign newest_inc = (newest_reg == LAST_IDX) ? '0 : newest_reg + 1'b1;
    assign ptr_dec    = (ptr_reg == '0) ? LAST_IDX : ptr_reg - 1'b1;
    assign n_int      = count_reg - 1'b1;
    assign wr_idx     = newest_inc;

    // sequence one command
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        newest_next  = newest_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        prev_t_next  = prev_t_reg;
        prev_l_next  = prev_l_reg;
        tneg_next    = tneg_reg;
        sneg_next    = sneg_reg;
        sum_next     = sum_reg;
        rate_next[0] = rate_reg[0];
        rate_next[1] = rate_reg[1];
        avg_next     = avg_reg;
        phi_next     = phi_reg;
        plo_next     = plo_reg;
        est_next     = est_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_nbits    = '0;
        cnt_base     = cmd_reg.clear ? '0 : count_reg;
        cnt_new      = (cnt_base == FULL_CNT) ? cnt_base : cnt_base + 1'b1;
        tdiff        = {1'b0, prev_t_reg} - {1'b0, rd_t_reg};
        tmag         = tdiff[bte_pkg::TIME_W] ? bte_pkg::TIME_W'(-tdiff)
                                              : tdiff[bte_pkg::TIME_W-1:0];
        cdiff        = (prev_l_reg >= rd_l_reg) ? prev_l_reg - rd_l_reg
                                                : rd_l_reg - prev_l_reg;
        qv           = div_quot;
        mag          = (qv > bte_pkg::AVG_MAX_MAG)
                       ? (sneg_reg ? bte_pkg::AVG_MAX_MAG + 1'b1 : bte_pkg::AVG_MAX_MAG) : qv;
        avg_new      = sneg_reg ? AW'(-mag) : mag[AW-1:0];
        mult         = cmd_reg.chg ? {1'b0, full_scale} - {1'b0, cmd_reg.cap}
                                   : {1'b0, cmd_reg.cap};
        m_abs        = mult[bte_pkg::CAP_W] ? bte_pkg::CAP_W'(-mult) : mult[bte_pkg::CAP_W-1:0];
        a_abs        = avg_reg[AW-1] ? -avg_reg : avg_reg;
        r_sum        = 47'(phi_reg) + 47'(plo_reg[29:FB]);

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!cmd_reg.store)
                begin
                    count_next = cnt_base;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_we      = 1'b1;
                    newest_next = newest_inc;
                    count_next  = cnt_new;
                    prev_t_next = cmd_reg.stamp;
                    prev_l_next = cmd_reg.cap;
                    ptr_next    = newest_inc;
                    k_next      = '0;
                    sum_next    = '0;
                    if (cnt_new >= CNT_W'(2))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        avg_next   = rate_reg[cmd_reg.chg];
                        state_next = S_MUL;
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                ptr_next   = ptr_dec;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                prev_t_next = rd_t_reg;
                prev_l_next = rd_l_reg;
                if (cdiff != '0)
                begin
                    div_start    = 1'b1;
                    div_dividend = {tmag, {FB{1'b0}}, {(DW-AW){1'b0}}};
                    div_divisor  = cdiff;
                    div_nbits    = bte_pkg::NB_INTERVAL;
                    tneg_next    = tdiff[bte_pkg::TIME_W];
                    state_next   = S_DIV;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    sum_next   = tneg_reg ? sum_reg - $signed(qv) : sum_reg + $signed(qv);
                    k_next     = k_reg + 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (k_reg == n_int)
                begin
                    div_start    = 1'b1;
                    div_dividend = sum_reg[DW-1] ? DW'(-sum_reg) : DW'(sum_reg);
                    div_divisor  = bte_pkg::CAP_W'(n_int);
                    div_nbits    = bte_pkg::NB_AVERAGE;
                    sneg_next    = sum_reg[DW-1];
                    state_next   = S_AVG;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_AVG:
            begin
                if (div_done)
                begin
                    rate_next[cmd_reg.chg] = avg_new;
                    avg_next               = avg_new;
                    state_next             = S_MUL;
                end
            end
            S_MUL:
            begin
                if ((mult == '0) || (avg_reg == '0) || (mult[bte_pkg::CAP_W] != avg_reg[AW-1]))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    phi_next   = 46'(m_abs) * 46'(a_abs[AW-1:FB]);
                    plo_next   = 30'(m_abs) * 30'(a_abs[FB-1:0]);
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (r_sum == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    est_next   = (r_sum > 47'(bte_pkg::EST_MAX)) ? bte_pkg::EST_MAX
                                                                 : r_sum[bte_pkg::EST_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!outv_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // raise the output beat on load, drop it once taken
        if (out_load)
        begin
            outv_next = 1'b1;
        end
        else
        begin
            outv_next = outv_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            newest_reg  <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            rate_reg[0] <= bte_pkg::AVG_RESET;
            rate_reg[1] <= bte_pkg::AVG_RESET;
            outv_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            newest_reg  <= newest_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            rate_reg[0] <= rate_next[0];
            rate_reg[1] <= rate_next[1];
            outv_reg    <= outv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ptr_reg    <= ptr_next;
        prev_t_reg <= prev_t_next;
        prev_l_reg <= prev_l_next;
        tneg_reg   <= tneg_next;
        sneg_reg   <= sneg_next;
        sum_reg    <= sum_next;
        avg_reg    <= avg_next;
        phi_reg    <= phi_next;
        plo_reg    <= plo_next;
        est_reg    <= est_next;
        if (out_load)
        begin
            oest_reg  <= est_reg;
            okind_reg <= cmd_reg.chg;
        end
    end

    // write and read the history
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_t[wr_idx] <= cmd_reg.stamp;
            mem_l[wr_idx] <= cmd_reg.cap;
        end
        if (rd_en)
        begin
            rd_t_reg <= mem_t[ptr_dec];
            rd_l_reg <= mem_l[ptr_dec];
        end
    end
endmodule
`default_nettype wire
